### src/brp_pkg.sv
// Shared types, codes and result builders for the base relocation parser.
package brp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE,
        PH_ERR
    } t_phase;

    localparam logic       ACT_START     = 1'b0;
    localparam logic       ACT_BYTE      = 1'b1;

    localparam logic [1:0] KIND_PATCH    = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_ERR      = 2'd2;

    localparam logic [1:0] WID_16        = 2'd0;
    localparam logic [1:0] WID_32        = 2'd1;
    localparam logic [1:0] WID_64        = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_DIR    = 3'd1;
    localparam logic [2:0] ERR_DIR_OUT   = 3'd2;
    localparam logic [2:0] ERR_BLK_SIZE  = 3'd3;
    localparam logic [2:0] ERR_TGT_OUT   = 3'd4;
    localparam logic [2:0] ERR_TYPE      = 3'd5;

    localparam logic [3:0] FIX_SKIP      = 4'd0;
    localparam logic [3:0] FIX_HI16      = 4'd1;
    localparam logic [3:0] FIX_LO16      = 4'd2;
    localparam logic [3:0] FIX_LO32      = 4'd3;
    localparam logic [3:0] FIX_FULL64    = 4'd10;

    localparam logic [4:0] DIR_IDX_RELOC = 5'd5;

    localparam logic [2:0] CFG_LOAD_DELTA  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_BYTES = 3'd1;
    localparam logic [2:0] CFG_DIR_OFFSET  = 3'd2;
    localparam logic [2:0] CFG_DIR_BYTES   = 3'd3;
    localparam logic [2:0] CFG_DIR_COUNT   = 3'd4;

    localparam int HDR_BYTES = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] target;
        logic [1:0]  width;
        logic [63:0] addend;
        logic [2:0]  err;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result f_done();
        t_result r;
        r        = '0;
        r.kind   = KIND_DONE;
        r.err    = ERR_NONE;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic t_result f_error(input logic [2:0] code);
        t_result r;
        r        = '0;
        r.kind   = KIND_ERR;
        r.err    = code;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

### src/brp_parser.sv
// Configuration registers, parse state and the per-word parse step.
module brp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_wdata,
    input  logic                i_accept,
    input  logic                i_action,
    input  logic [7:0]          i_dir_byte,
    output brp_pkg::t_push      o_push
);

    logic [63:0]     r_load_delta;
    logic [29:0]     r_image_bytes;
    logic [29:0]     r_dir_offset;
    logic [29:0]     r_dir_bytes;
    logic [4:0]      r_dir_count;

    logic [29:0]     r_dir_pos,    n_dir_pos;
    logic [29:0]     r_block_pos,  n_block_pos;
    logic [31:0]     r_page_base,  n_page_base;
    logic [31:0]     r_block_bytes, n_block_bytes;
    logic [7:0]      r_entry_low,  n_entry_low;
    brp_pkg::t_phase r_phase,      n_phase;

    logic [29:0]     start;
    logic [29:0]     bp_next;
    logic [30:0]     bp_inc;
    logic [32:0]     tgt;
    logic [3:0]      rtype;
    logic            halt;
    logic            patch;
    brp_pkg::t_result patch_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_delta  <= '0;
            r_image_bytes <= '0;
            r_dir_offset  <= '0;
            r_dir_bytes   <= '0;
            r_dir_count   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                brp_pkg::CFG_LOAD_DELTA:  r_load_delta  <= i_cfg_wdata;
                brp_pkg::CFG_IMAGE_BYTES: r_image_bytes <= i_cfg_wdata[29:0];
                brp_pkg::CFG_DIR_OFFSET:  r_dir_offset  <= i_cfg_wdata[29:0];
                brp_pkg::CFG_DIR_BYTES:   r_dir_bytes   <= i_cfg_wdata[29:0];
                brp_pkg::CFG_DIR_COUNT:   r_dir_count   <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_pos     <= '0;
            r_block_pos   <= '0;
            r_page_base   <= '0;
            r_block_bytes <= '0;
            r_entry_low   <= '0;
            r_phase       <= brp_pkg::PH_IDLE;
        end else begin
            r_dir_pos     <= n_dir_pos;
            r_block_pos   <= n_block_pos;
            r_page_base   <= n_page_base;
            r_block_bytes <= n_block_bytes;
            r_entry_low   <= n_entry_low;
            r_phase       <= n_phase;
        end
    end

    always_comb begin
        n_dir_pos     = r_dir_pos;
        n_block_pos   = r_block_pos;
        n_page_base   = r_page_base;
        n_block_bytes = r_block_bytes;
        n_entry_low   = r_entry_low;
        n_phase       = r_phase;
        o_push        = '0;
        start         = r_dir_pos - r_block_pos;
        bp_next       = r_block_pos;
        bp_inc        = {1'b0, r_block_pos} + 31'd1;
        tgt           = {1'b0, r_page_base} + {21'b0, i_dir_byte[3:0], r_entry_low};
        rtype         = i_dir_byte[7:4];
        halt          = 1'b0;
        patch         = 1'b0;
        patch_res     = '0;
        patch_res.kind = brp_pkg::KIND_PATCH;
        patch_res.target = tgt[28:0];

        if (i_accept) begin
            unique case (i_action)
                brp_pkg::ACT_START: begin
                    n_dir_pos     = '0;
                    n_block_pos   = '0;
                    n_page_base   = '0;
                    n_block_bytes = '0;
                    n_entry_low   = '0;
                    o_push.count  = 2'd1;
                    if (r_load_delta == 64'd0) begin
                        n_phase      = brp_pkg::PH_DONE;
                        o_push.first = brp_pkg::f_done();
                    end else if (r_dir_count <= brp_pkg::DIR_IDX_RELOC
                                 || r_dir_offset == 30'd0 || r_dir_bytes == 30'd0) begin
                        n_phase      = brp_pkg::PH_ERR;
                        o_push.first = brp_pkg::f_error(brp_pkg::ERR_NO_DIR);
                    end else if (({1'b0, r_dir_offset} + {1'b0, r_dir_bytes})
                                 > {1'b0, r_image_bytes}) begin
                        n_phase      = brp_pkg::PH_ERR;
                        o_push.first = brp_pkg::f_error(brp_pkg::ERR_DIR_OUT);
                    end else begin
                        n_phase      = brp_pkg::PH_RUN;
                        o_push.count = 2'd0;
                    end
                end
                brp_pkg::ACT_BYTE: begin
                    if (r_phase == brp_pkg::PH_RUN) begin
                        if (r_block_pos[29:3] == 27'd0) begin
                            if (({1'b0, start} + 31'd8) <= {1'b0, r_dir_bytes}) begin
                                if (!r_block_pos[2]) begin
                                    if (r_block_pos[1:0] == 2'd0) begin
                                        n_page_base = {24'b0, i_dir_byte};
                                    end else begin
                                        n_page_base[{r_block_pos[1:0], 3'b000} +: 8] =
                                            i_dir_byte;
                                    end
                                end else begin
                                    if (r_block_pos[1:0] == 2'd0) begin
                                        n_block_bytes = {24'b0, i_dir_byte};
                                    end else begin
                                        n_block_bytes[{r_block_pos[1:0], 3'b000} +: 8] =
                                            i_dir_byte;
                                    end
                                end
                                bp_next = bp_inc[29:0];
                                if (r_block_pos[2:0] == 3'd7) begin
                                    if (n_block_bytes < 32'(brp_pkg::HDR_BYTES)
                                        || ({3'b0, start} + {1'b0, n_block_bytes})
                                           > {3'b0, r_dir_bytes}) begin
                                        halt         = 1'b1;
                                        n_phase      = brp_pkg::PH_ERR;
                                        o_push.count = 2'd1;
                                        o_push.first =
                                            brp_pkg::f_error(brp_pkg::ERR_BLK_SIZE);
                                    end else if (n_block_bytes
                                                 == 32'(brp_pkg::HDR_BYTES)) begin
                                        bp_next = '0;
                                    end
                                end
                                if (!halt) begin
                                    n_block_pos = bp_next;
                                end
                            end
                        end else begin
                            if (!r_block_pos[0]) begin
                                n_entry_low = i_dir_byte;
                            end else if (rtype != brp_pkg::FIX_SKIP) begin
                                if (({1'b0, tgt} + 34'd8) > {4'b0, r_image_bytes}) begin
                                    halt         = 1'b1;
                                    n_phase      = brp_pkg::PH_ERR;
                                    o_push.count = 2'd1;
                                    o_push.first = brp_pkg::f_error(brp_pkg::ERR_TGT_OUT);
                                end else begin
                                    case (rtype)
                                        brp_pkg::FIX_FULL64: begin
                                            patch           = 1'b1;
                                            patch_res.width = brp_pkg::WID_64;
                                            patch_res.addend = r_load_delta;
                                        end
                                        brp_pkg::FIX_LO32: begin
                                            patch           = 1'b1;
                                            patch_res.width = brp_pkg::WID_32;
                                            patch_res.addend = {32'b0, r_load_delta[31:0]};
                                        end
                                        brp_pkg::FIX_HI16: begin
                                            patch           = 1'b1;
                                            patch_res.width = brp_pkg::WID_16;
                                            patch_res.addend = {48'b0, r_load_delta[31:16]};
                                        end
                                        brp_pkg::FIX_LO16: begin
                                            patch           = 1'b1;
                                            patch_res.width = brp_pkg::WID_16;
                                            patch_res.addend = {48'b0, r_load_delta[15:0]};
                                        end
                                        default: begin
                                            halt         = 1'b1;
                                            n_phase      = brp_pkg::PH_ERR;
                                            o_push.count = 2'd1;
                                            o_push.first =
                                                brp_pkg::f_error(brp_pkg::ERR_TYPE);
                                        end
                                    endcase
                                end
                            end
                            if (!halt) begin
                                if ({1'b0, bp_inc} >= r_block_bytes) begin
                                    n_block_pos = '0;
                                end else begin
                                    n_block_pos = bp_inc[29:0];
                                end
                            end
                        end

                        if (!halt) begin
                            n_dir_pos = r_dir_pos + 30'd1;
                            if (patch) begin
                                o_push.count = 2'd1;
                                o_push.first = patch_res;
                            end
                            if (n_dir_pos >= r_dir_bytes) begin
                                n_phase = brp_pkg::PH_DONE;
                                if (patch) begin
                                    o_push.count  = 2'd2;
                                    o_push.second = brp_pkg::f_done();
                                end else begin
                                    o_push.count = 2'd1;
                                    o_push.first = brp_pkg::f_done();
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### src/brp_out_fifo.sv
// Result word queue: takes up to two words per cycle, delivers one per cycle unless stalled.
module brp_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brp_pkg::t_push    i_push,
    output logic              o_full2,
    output logic              o_valid,
    input  logic              i_stall,
    output brp_pkg::t_result  o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    brp_pkg::t_result mem [DEPTH];

    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic [PW-1:0] wr_ptr1;
    logic          pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PW'(1);
        end
        return q;
    endfunction

    assign o_valid = (r_count != '0);
    assign o_full2 = (r_count > CW'(DEPTH - 2));
    assign o_data  = mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    assign wr_ptr1 = f_inc(r_wr_ptr);

    always_comb begin
        n_rd_ptr = pop ? f_inc(r_rd_ptr) : r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        case (i_push.count)
            2'd1:    n_wr_ptr = wr_ptr1;
            2'd2:    n_wr_ptr = f_inc(wr_ptr1);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + CW'(i_push.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            mem[wr_ptr1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### src/pe_base_reloc_parser.sv
// Top level of the streamed PE32+ base relocation directory parser.
// One input word (a start command or one directory byte) is taken every cycle
// while at least two entries of the result queue are free; each word is parsed
// in the cycle it is accepted and yields zero, one or two result words, which
// are registered in the result queue and drain one per cycle while the consumer
// does not stall. The rate is set by the combinational parse step and the
// one-word-per-cycle queue read port; with FIFO_DEPTH entries (at least four)
// the input stalls only while the consumer holds back results.
module pe_base_reloc_parser #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_dir_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [28:0] o_patch_target,
    output logic [1:0]  o_patch_width,
    output logic [63:0] o_patch_addend,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    brp_pkg::t_push   push;
    brp_pkg::t_result res;
    logic             full2;
    logic             accept;

    assign o_in_stall = full2;
    assign accept     = i_in_valid && !full2;

    brp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_dir_byte  (i_dir_byte),
        .o_push      (push)
    );

    brp_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full2 (full2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (res)
    );

    assign o_kind         = res.kind;
    assign o_patch_target = res.target;
    assign o_patch_width  = res.width;
    assign o_patch_addend = res.addend;
    assign o_error_code   = res.err;
    assign o_last         = res.last;

endmodule
